// ----- design/plist_pkg.sv -----
// Shared types, constants and helpers for the positional insert list.
`default_nettype none
package plist_pkg;

  // List depth and derived widths
  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SPLIT  = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [ST_W-1:0] ST_ELEMENT  = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

  // Cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_SHIFT  = 2'd1;
  localparam logic [1:0] CELL_LOAD   = 2'd2;
  localparam logic [1:0] CELL_ROTATE = 2'd3;

  typedef struct packed {
    logic                    command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] element;
    logic                    group;
    logic [POS_W-1:0]        entry_count;
    logic                    last;
  } res_t;

  // Per-cell control word
  typedef struct packed {
    logic [1:0] op;
    logic       wrap;
  } cell_ctl_t;

  function automatic logic is_positive(input logic [VAL_W-1:0] v);
    is_positive = (v != '0) && !v[VAL_W-1];
  endfunction

endpackage
`default_nettype wire

// ----- design/plist_cell.sv -----
// One storage cell of the list chain: hold, shift up, load or rotate down.
`default_nettype none
module plist_cell
  import plist_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [VAL_W-1:0] left,
  input  wire logic [VAL_W-1:0] right,
  input  wire logic [VAL_W-1:0] head,
  input  wire logic [VAL_W-1:0] load_val,
  output logic      [VAL_W-1:0] q
);

  logic [VAL_W-1:0] q_next;

  // next value select
  always_comb begin
    case (ctl.op)
      CELL_HOLD:   q_next = q;
      CELL_SHIFT:  q_next = left;
      CELL_LOAD:   q_next = load_val;
      CELL_ROTATE: q_next = ctl.wrap ? head : right;
      default:     q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire

// ----- design/positional_insert_list_with_split.sv -----
// Top level: ordered value list built from a chain of shifting cells.
`default_nettype none
// Ordered list of signed 32-bit values held in a chain of DEPTH cells. An
// insert first accepts the word, then shifts the chain and posts its status
// word once the result register is free. A split rotates the whole chain
// through cell 0 twice (positive pass, then zero/negative pass), one cell
// per cycle while the result side does not stall; the list is back in its
// original order when it ends. One command word is worked on at a time; a
// finished result word sits in an output register while the next command
// word is taken.
module positional_insert_list_with_split
  import plist_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_INS   = 2'd1;
  localparam logic [1:0] S_SPLIT = 2'd2;
  localparam int CMP_W = POS_W + 1;

  logic [1:0]       state;
  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] step;
  logic [IDX_W-1:0] emit_cnt;
  logic             pass;

  logic [VAL_W-1:0] cells [DEPTH];
  cell_ctl_t        ctls  [DEPTH];

  logic             res_free;
  logic             accept;
  logic [ST_W-1:0]  ins_status;
  logic             ins_do;
  logic             rot;
  logic             qual;
  logic             emit;
  logic             pass_end;
  logic [CNT_W-1:0] cnt_m1;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_p1;

  assign res_free  = !res_valid || res_ready;
  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;

  // insert checks
  assign pos_x  = CMP_W'(pos);
  assign cnt_p1 = CMP_W'(cnt) + CMP_W'(1);
  always_comb begin
    if (cnt == CNT_W'(DEPTH)) begin
      ins_status = ST_FULL;
    end else if (pos == '0 || pos_x > cnt_p1) begin
      ins_status = ST_BADPOS;
    end else begin
      ins_status = ST_INSERTED;
    end
  end
  assign ins_do = (state == S_INS) && res_free && (ins_status == ST_INSERTED);

  // split sequencing: head of chain qualifies for current pass
  assign cnt_m1   = cnt - CNT_W'(1);
  assign qual     = pass ? !is_positive(cells[0]) : is_positive(cells[0]);
  assign emit     = (state == S_SPLIT) && (cnt != '0) && qual && res_free;
  assign rot      = (state == S_SPLIT) && (cnt != '0) && (!qual || res_free);
  assign pass_end = (CNT_W'(step) == cnt_m1);

  // cell chain
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX1 = CMP_W'(i + 1);
      logic [VAL_W-1:0] left_in;
      logic [VAL_W-1:0] right_in;

      if (i == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_mid
        assign left_in = cells[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
        assign right_in = cells[0];
      end else begin : g_inner
        assign right_in = cells[i+1];
      end

      always_comb begin
        ctls[i].wrap = (CNT_W'(i) == cnt_m1);
        if (ins_do) begin
          if (IDX1 == pos_x) begin
            ctls[i].op = CELL_LOAD;
          end else if (IDX1 > pos_x) begin
            ctls[i].op = CELL_SHIFT;
          end else begin
            ctls[i].op = CELL_HOLD;
          end
        end else if (rot) begin
          ctls[i].op = CELL_ROTATE;
        end else begin
          ctls[i].op = CELL_HOLD;
        end
      end

      plist_cell u_cell (
        .clk      (clk),
        .ctl      (ctls[i]),
        .left     (left_in),
        .right    (right_in),
        .head     (cells[0]),
        .load_val (val),
        .q        (cells[i])
      );
    end
  endgenerate

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      step     <= '0;
      emit_cnt <= '0;
      pass     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            step     <= '0;
            emit_cnt <= '0;
            pass     <= 1'b0;
            state    <= (cmd.command == CMD_SPLIT) ? S_SPLIT : S_INS;
          end
        end
        S_INS: begin
          if (res_free) begin
            if (ins_status == ST_INSERTED) begin
              cnt <= cnt + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        S_SPLIT: begin
          if (cnt == '0) begin
            if (res_free) begin
              state <= S_IDLE;
            end
          end else if (rot) begin
            if (emit) begin
              emit_cnt <= emit_cnt + IDX_W'(1);
            end
            if (pass_end) begin
              step <= '0;
              pass <= 1'b1;
              if (pass) begin
                state <= S_IDLE;
              end
            end else begin
              step <= step + IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      pos <= cmd.position;
      val <= cmd.value;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_INS && res_free) || emit ||
                 (state == S_SPLIT && cnt == '0 && res_free)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_INS && res_free) begin
      res.status      <= ins_status;
      res.element     <= '0;
      res.group       <= 1'b0;
      res.entry_count <= POS_W'((ins_status == ST_INSERTED) ? cnt + CNT_W'(1) : cnt);
      res.last        <= 1'b1;
    end else if (emit) begin
      res.status      <= ST_ELEMENT;
      res.element     <= cells[0];
      res.group       <= pass;
      res.entry_count <= POS_W'(cnt);
      res.last        <= (CNT_W'(emit_cnt) == cnt_m1);
    end else if (state == S_SPLIT && cnt == '0 && res_free) begin
      res.status      <= ST_EMPTY;
      res.element     <= '0;
      res.group       <= 1'b0;
      res.entry_count <= '0;
      res.last        <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- dv/tb_positional_insert_list_with_split.sv -----
// Testbench for the positional insert list: directed and random commands, scoreboard check.
`timescale 1ns / 1ps

import plist_pkg::*;

// Tracks the list contents and the result words each command should produce
class list_scoreboard;
  logic signed [VAL_W-1:0] entries [DEPTH];
  int                      count;
  res_t                    pending_results [$];
  int                      errors;

  function new();
    count  = 0;
    errors = 0;
  endfunction

  // Update the list copy for an accepted command word and queue its results
  function void apply_command(cmd_t c);
    res_t r;
    res_t readout [$];
    int   i;
    r      = '0;
    r.last = 1'b1;
    if (c.command == CMD_INSERT) begin
      if (count >= DEPTH) begin
        r.status = ST_FULL;
      end else if (c.position == 0 || int'(c.position) > count + 1) begin
        r.status = ST_BADPOS;
      end else begin
        for (i = count; i >= int'(c.position); i--) entries[i] = entries[i-1];
        entries[int'(c.position) - 1] = c.value;
        count++;
        r.status = ST_INSERTED;
      end
      r.entry_count = POS_W'(count);
      pending_results.push_back(r);
    end else if (count == 0) begin
      r.status = ST_EMPTY;
      pending_results.push_back(r);
    end else begin
      // positive entries first, then zero and negative, both in list order
      r.status      = ST_ELEMENT;
      r.entry_count = POS_W'(count);
      r.last        = 1'b0;
      for (i = 0; i < count; i++) begin
        if (entries[i] > 0) begin
          r.element = entries[i];
          r.group   = 1'b0;
          readout.push_back(r);
        end
      end
      for (i = 0; i < count; i++) begin
        if (!(entries[i] > 0)) begin
          r.element = entries[i];
          r.group   = 1'b1;
          readout.push_back(r);
        end
      end
      readout[readout.size() - 1].last = 1'b1;
      foreach (readout[k]) pending_results.push_back(readout[k]);
    end
  endfunction

  function void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare an accepted result word against the oldest expectation
  function void check_result(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result word, status %0d element %0d count %0d",
               $time, got.status, got.element, got.entry_count);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("element", want.element, got.element);
    compare_field("group", want.group, got.group);
    compare_field("entry_count", want.entry_count, got.entry_count);
    compare_field("last", want.last, got.last);
  endfunction
endclass

module tb_positional_insert_list_with_split;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_WORDS  = 170;
  localparam int IDLE_PERCENT  = 17;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;

  list_scoreboard sb = new();
  bit             quiet;
  int             cycle_count;

  positional_insert_list_with_split u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random backpressure, check every accepted word
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) sb.check_result(res);
      res_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic cmd_t make_word(logic c, int pos, logic [VAL_W-1:0] val);
    cmd_t w;
    w.command  = c;
    w.position = POS_W'(pos);
    w.value    = val;
    return w;
  endfunction

  // Values biased toward the extremes and zero
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return 32'h7fff_ffff;
      4:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Drive one command word, with random idle cycles ahead of it
  task automatic send_word(cmd_t w);
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sb.apply_command(w);
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Random command: mostly valid inserts, some bad positions, some splits
  task automatic send_random_word();
    int   roll;
    int   pos;
    cmd_t w;
    roll = $urandom_range(99);
    if (roll < 15) begin
      w = make_word(CMD_SPLIT, $urandom_range(127), $urandom);
    end else if (roll < 25) begin
      if (sb.count + 2 <= 127 && $urandom_range(3) != 0)
        pos = $urandom_range(127, sb.count + 2);
      else
        pos = 0;
      w = make_word(CMD_INSERT, pos, pick_value());
    end else begin
      w = make_word(CMD_INSERT, $urandom_range(sb.count + 1, 1), pick_value());
    end
    send_word(w);
  endtask

  // Stimulus
  initial begin
    rst         <= 1'b1;
    cmd_valid   <= 1'b0;
    cmd         <= '0;
    cycle_count <= 0;
    quiet        = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty split, position limits, value extremes, ignored split fields
    send_word(make_word(CMD_SPLIT, 0, '0));
    send_word(make_word(CMD_INSERT, 0, 32'sd5));
    send_word(make_word(CMD_INSERT, 2, 32'sd5));
    send_word(make_word(CMD_INSERT, 127, 32'hffff_ffff));
    send_word(make_word(CMD_INSERT, 1, '0));
    send_word(make_word(CMD_INSERT, 2, 32'h7fff_ffff));
    send_word(make_word(CMD_INSERT, 1, 32'h8000_0000));
    send_word(make_word(CMD_INSERT, 4, 32'sd1));
    send_word(make_word(CMD_INSERT, 3, -32'sd1));
    send_word(make_word(CMD_INSERT, 7, 32'sd9));
    send_word(make_word(CMD_SPLIT, 127, 32'hffff_ffff));
    send_word(make_word(CMD_INSERT, 6, 32'h1234_5678));
    send_word(make_word(CMD_SPLIT, 0, '0));

    // random: list fills up, then full rejects and long readouts
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet = (n >= 40 && n < 80);
      if (n == 100) begin
        cmd_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      send_random_word();
    end
    quiet = 1'b0;
    cmd_valid <= 1'b0;

    wait_drained();
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
